>>> sv/dedup_fingerprint_refcount_table_assert.svh
// Assertion macros for the fingerprint index block.
`ifndef DEDUP_FINGERPRINT_REFCOUNT_TABLE_ASSERT_SVH
`define DEDUP_FINGERPRINT_REFCOUNT_TABLE_ASSERT_SVH
`define DFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> sv/dfrt_pkg.sv
// ----------------------------------------------------------------------------
// dfrt_pkg
// Types and constants shared by the fingerprint index block.
// ----------------------------------------------------------------------------
package dfrt_pkg;
    localparam int unsigned BUCKETS   = 1024;
    localparam int unsigned WAYS      = 4;
    localparam int unsigned LOG_SLOTS = 4096;
    localparam int unsigned BKT_W  = $clog2(BUCKETS);
    localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned IDX_W  = $clog2(BUCKETS * WAYS);
    localparam int unsigned SLOT_W = $clog2(LOG_SLOTS);

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_LOOKUP  = 2'd2,
        CMD_LOOKUP3 = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_DUP      = 3'd1,
        ST_DEC      = 3'd2,
        ST_FREED    = 3'd3,
        ST_FOUND    = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_BKTFULL  = 3'd6,
        ST_LOGFULL  = 3'd7
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] fp_low;
        logic [63:0] fp_mid;
        logic [31:0] fp_high;
        logic [18:0] chunk_len;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] log_slot;
        logic [47:0] data_offset;
        logic [31:0] use_count;
        logic [18:0] stored_size;
    } t_out;

    // bucket result handed from front to back
    typedef struct packed {
        t_in               item;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [SLOT_W-1:0] hit_slot;
        logic              has_empty;
        logic [IDX_W-1:0]  empty_idx;
    } t_cls;

    // index update from back to front
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [63:0]       k_low;
        logic [63:0]       k_mid;
        logic [31:0]       k_high;
        logic [SLOT_W-1:0] slot;
    } t_iwr;
endpackage

>>> sv/dfrt_front.sv
// ----------------------------------------------------------------------------
// dfrt_front
// Index lookup: read the bucket ways in turn and classify the item.
// ----------------------------------------------------------------------------
module dfrt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  dfrt_pkg::t_in    i_item,
    output logic             o_busy,
    output logic             o_cls_valid,
    output dfrt_pkg::t_cls   o_cls,
    input  logic             i_cls_ready,
    input  logic             i_back_idle,
    input  dfrt_pkg::t_iwr   i_iwr
);
    localparam int unsigned ENT = dfrt_pkg::BUCKETS * dfrt_pkg::WAYS;
    localparam int unsigned KW  = 64 + 64 + 32 + dfrt_pkg::SLOT_W;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CMP, S_WAIT, S_SYNC} t_state;

    logic [KW-1:0] r_mem [ENT];
    logic [KW-1:0] r_rd;
    t_state r_state;
    logic [dfrt_pkg::IDX_W:0] r_clr;
    dfrt_pkg::t_in r_item;
    logic [dfrt_pkg::BKT_W-1:0] r_bkt;
    logic [dfrt_pkg::WAY_W:0] r_way;
    logic r_hit, r_emp;
    logic [dfrt_pkg::IDX_W-1:0] r_hidx, r_eidx;
    logic [dfrt_pkg::SLOT_W-1:0] r_hslot;
    logic [dfrt_pkg::IDX_W-1:0] n_addr, w_cur;
    logic [dfrt_pkg::SLOT_W-1:0] w_slot;

    assign n_addr = dfrt_pkg::IDX_W'(r_bkt * dfrt_pkg::WAYS)
                  + dfrt_pkg::IDX_W'(r_way);
    assign w_cur  = n_addr;
    assign w_slot = r_rd[dfrt_pkg::SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr[dfrt_pkg::IDX_W-1:0]] <= '0;
        end else if (i_iwr.we) begin
            r_mem[i_iwr.idx] <= {i_iwr.k_low, i_iwr.k_mid, i_iwr.k_high, i_iwr.slot};
        end
        r_rd <= r_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_way   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (dfrt_pkg::IDX_W+1)'(ENT - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_bkt   <= dfrt_pkg::BKT_W'(i_item.fp_high % dfrt_pkg::BUCKETS);
                        r_way   <= '0;
                        r_hit   <= 1'b0;
                        r_emp   <= 1'b0;
                        r_state <= S_SYNC;
                    end
                end
                S_SYNC: begin
                    if (i_back_idle) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_CMP;
                S_CMP: begin
                    if (w_slot == '0) begin
                        if (!r_emp) begin
                            r_emp  <= 1'b1;
                            r_eidx <= w_cur;
                        end
                    end else if (!r_hit && r_rd[KW-1 -: 64] == r_item.fp_low
                                 && r_rd[KW-65 -: 64] == r_item.fp_mid
                                 && r_rd[KW-129 -: 32] == r_item.fp_high) begin
                        r_hit   <= 1'b1;
                        r_hidx  <= w_cur;
                        r_hslot <= w_slot;
                    end
                    if (r_way == (dfrt_pkg::WAY_W+1)'(dfrt_pkg::WAYS - 1)) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_way   <= r_way + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_WAIT: if (i_cls_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cls_valid = (r_state == S_WAIT);
    assign o_cls = '{item: r_item, hit: r_hit, hit_idx: r_hidx, hit_slot: r_hslot,
                     has_empty: r_emp, empty_idx: r_eidx};
endmodule

>>> sv/dfrt_back.sv
// ----------------------------------------------------------------------------
// dfrt_back
// Log update: free list, bump allocator, count read-modify-write, result.
// ----------------------------------------------------------------------------
module dfrt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cls_valid,
    input  dfrt_pkg::t_cls   i_cls,
    output logic             o_cls_ready,
    output logic             o_idle,
    output dfrt_pkg::t_iwr   o_iwr,
    output logic             o_done,
    output dfrt_pkg::t_out   o_res
);
    localparam int unsigned SW = dfrt_pkg::SLOT_W;
    typedef enum logic [2:0] {S_IDLE, S_RD, S_EXE, S_OUT} t_state;

    logic [31:0] r_cnt [dfrt_pkg::LOG_SLOTS];
    logic [47:0] r_off [dfrt_pkg::LOG_SLOTS];
    logic [18:0] r_siz [dfrt_pkg::LOG_SLOTS];
    logic [SW-1:0] r_nxt [dfrt_pkg::LOG_SLOTS];
    logic [SW:0] r_fill;  // slots below this were linked by the allocator
    logic [SW-1:0] r_head;
    logic [47:0] r_alloc;
    t_state r_state;
    dfrt_pkg::t_cls r_c;
    logic [SW-1:0] r_slot;
    logic [31:0] r_rcnt;
    logic [47:0] r_roff;
    logic [18:0] r_rsiz;
    logic [SW-1:0] r_rnxt;
    logic [SW:0] r_rnxt_def;
    logic r_nxt_valid;
    logic [SW-1:0] w_rslot;
    logic w_alloc, w_free;
    dfrt_pkg::t_iwr n_iwr;

    assign w_rslot = r_c.hit ? r_c.hit_slot : r_head;
    assign w_alloc = (r_state == S_EXE) && r_c.item.command == dfrt_pkg::CMD_WRITE
                     && !r_c.hit && r_head != '0 && r_c.has_empty;
    assign w_free  = (r_state == S_EXE) && r_c.item.command == dfrt_pkg::CMD_RELEASE
                     && r_c.hit && r_rcnt <= 32'd1;

    always_comb begin
        n_iwr = '0;
        if (w_alloc) begin
            n_iwr = '{1'b1, r_c.empty_idx, r_c.item.fp_low, r_c.item.fp_mid,
                      r_c.item.fp_high, r_slot};
        end else if (w_free) begin
            n_iwr = '{1'b1, r_c.hit_idx, 64'd0, 64'd0, 32'd0, SW'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= SW'(1);
            r_alloc <= '0;
            r_fill  <= '0;
            o_done  <= 1'b0;
            o_iwr   <= '0;
        end else begin
            o_done <= (r_state == S_OUT);
            o_iwr  <= n_iwr;
            unique case (r_state)
                S_IDLE: if (i_cls_valid) begin
                    r_c     <= i_cls;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_slot  <= w_rslot;
                    r_rcnt  <= r_cnt[w_rslot];
                    r_roff  <= r_off[w_rslot];
                    r_rsiz  <= r_siz[w_rslot];
                    r_rnxt  <= r_nxt[w_rslot];
                    r_nxt_valid <= ({1'b0, w_rslot} < r_fill);
                    r_rnxt_def  <= {1'b0, w_rslot} + 1'b1;
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    r_state <= S_OUT;
                    if (r_c.item.command == dfrt_pkg::CMD_WRITE) begin
                        if (r_c.hit) begin
                            if (r_rcnt != 32'hFFFF_FFFF) r_cnt[r_slot] <= r_rcnt + 1'b1;
                            o_res <= '{dfrt_pkg::ST_DUP, 12'(r_slot), r_roff,
                                       (r_rcnt != 32'hFFFF_FFFF) ? r_rcnt + 1'b1 : r_rcnt,
                                       r_rsiz};
                        end else if (r_head == '0) begin
                            o_res <= '{dfrt_pkg::ST_LOGFULL, 12'd0, 48'd0, 32'd0, 19'd0};
                        end else if (!r_c.has_empty) begin
                            o_res <= '{dfrt_pkg::ST_BKTFULL, 12'd0, 48'd0, 32'd0, 19'd0};
                        end else begin
                            r_head <= r_nxt_valid ? r_rnxt :
                                      (r_rnxt_def == (SW+1)'(dfrt_pkg::LOG_SLOTS)) ? '0
                                      : r_rnxt_def[SW-1:0];
                            r_cnt[r_slot] <= 32'd1;
                            r_off[r_slot] <= r_alloc;
                            r_siz[r_slot] <= r_c.item.chunk_len;
                            r_alloc <= r_alloc + 48'(r_c.item.chunk_len);
                            o_res <= '{dfrt_pkg::ST_NEW, 12'(r_slot), r_alloc, 32'd1,
                                       r_c.item.chunk_len};
                        end
                    end else if (!r_c.hit) begin
                        o_res <= '{dfrt_pkg::ST_NOTFOUND, 12'd0, 48'd0, 32'd0, 19'd0};
                    end else if (r_c.item.command == dfrt_pkg::CMD_RELEASE) begin
                        if (r_rcnt > 32'd1) begin
                            r_cnt[r_slot] <= r_rcnt - 1'b1;
                            o_res <= '{dfrt_pkg::ST_DEC, 12'(r_slot), r_roff,
                                       r_rcnt - 1'b1, r_rsiz};
                        end else begin
                            r_cnt[r_slot] <= '0;
                            o_res <= '{dfrt_pkg::ST_FREED, 12'(r_slot), r_roff, 32'd0,
                                       r_rsiz};
                            r_nxt[r_slot] <= r_head;
                            r_head <= r_slot;
                        end
                    end else begin
                        o_res <= '{dfrt_pkg::ST_FOUND, 12'(r_slot), r_roff, r_rcnt, r_rsiz};
                    end
                end
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if ((w_alloc || w_free) && {1'b0, r_slot} >= r_fill) begin
                r_fill <= {1'b0, r_slot} + 1'b1;
            end
        end
    end

    assign o_cls_ready = (r_state == S_IDLE);
    assign o_idle      = (r_state == S_IDLE) && !o_iwr.we;
endmodule

>>> sv/dedup_fingerprint_refcount_table.sv
// ----------------------------------------------------------------------------
// dedup_fingerprint_refcount_table
// Fingerprint index with reference-counted log, free list and data allocator.
// ----------------------------------------------------------------------------
// channel   ports                        handshake
// request   i_start, i_req, o_busy       taken when i_start && !o_busy
// result    o_done, o_res                valid one cycle with o_done
//
// After accept, the bucket ways are read in turn on the index memory port,
// each in S_READ then S_CMP; then the log side does its RMW and raises o_done.
// A request taken while the log side still works on the previous item waits
// in S_SYNC until the log side is idle and its index write has landed.
// After reset the index memory is cleared one entry per cycle
// (all BUCKETS*WAYS = 4096 entries) with o_busy high.
// The receiver cannot stall; o_res holds until the next result.
module dedup_fingerprint_refcount_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  dfrt_pkg::t_in   i_req,
    output logic            o_busy,
    output logic            o_done,
    output dfrt_pkg::t_out  o_res
);
    logic cls_valid, cls_ready, back_idle;
    dfrt_pkg::t_cls cls;
    dfrt_pkg::t_iwr iwr;

    dfrt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_req),
        .o_busy(o_busy), .o_cls_valid(cls_valid), .o_cls(cls),
        .i_cls_ready(cls_ready), .i_back_idle(back_idle), .i_iwr(iwr)
    );

    dfrt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cls_valid(cls_valid), .i_cls(cls),
        .o_cls_ready(cls_ready), .o_idle(back_idle), .o_iwr(iwr),
        .o_done(o_done), .o_res(o_res)
    );
endmodule

>>> sv/dfrt_checker.sv
// ----------------------------------------------------------------------------
// dfrt_checker
// Port-level checks of the fingerprint index block.
// ----------------------------------------------------------------------------
`include "dedup_fingerprint_refcount_table_assert.svh"
module dfrt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input logic           o_busy,
    input logic           o_done,
    input dfrt_pkg::t_out o_res
);
    `DFR_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `DFR_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `DFR_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n,
        o_done && (o_res.status == dfrt_pkg::ST_NOTFOUND ||
                   o_res.status == dfrt_pkg::ST_BKTFULL ||
                   o_res.status == dfrt_pkg::ST_LOGFULL), o_res.log_slot == '0)
    `DFR_ASSERT_IMPL(a_new_one, i_clk, i_rst_n,
        o_done && o_res.status == dfrt_pkg::ST_NEW,
        o_res.use_count == 32'd1 && o_res.log_slot != '0)
endmodule

bind dedup_fingerprint_refcount_table dfrt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_done(o_done), .o_res(o_res)
);
